// File: sv/rks_pkg.sv
// Shared constants and codes for the range k-th smallest block.
package rks_pkg;

    localparam int DEFAULT_DEPTH      = 1024;
    localparam int DEFAULT_VALUE_BITS = 32;

    localparam int PW          = 11;
    localparam int VALUE_W     = 32;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 32;

    localparam logic [PW-1:0] CFG_LEN_RESET = PW'(1024);

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

endpackage

// File: sv/rks_store.sv
// Element store: one write port, one registered read port.
module rks_store #(
    parameter int DEPTH = rks_pkg::DEFAULT_DEPTH,
    parameter int VALUE_BITS = rks_pkg::DEFAULT_VALUE_BITS,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  logic [VALUE_BITS-1:0] i_wdata,
    input  logic                  i_re,
    input  logic [AW-1:0]         i_raddr,
    output logic [VALUE_BITS-1:0] o_rdata
);

    logic [VALUE_BITS-1:0] r_mem [DEPTH];
    logic [VALUE_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/rks_engine.sv
// Sequencer: clear pass, element writes and bitwise radix select over the store.
module rks_engine #(
    parameter int DEPTH = rks_pkg::DEFAULT_DEPTH,
    parameter int VALUE_BITS = rks_pkg::DEFAULT_VALUE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [rks_pkg::PW-1:0]        i_cfg_len,
    input  logic                          i_req_valid,
    output logic                          o_req_ready,
    input  logic                          i_kind,
    input  logic [rks_pkg::PW-1:0]        i_position,
    input  logic [rks_pkg::PW-1:0]        i_range_end,
    input  logic [rks_pkg::VALUE_W-1:0]   i_new_value,
    input  logic [rks_pkg::PW-1:0]        i_rank,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output logic [rks_pkg::VALUE_W-1:0]   o_kth_value,
    output logic                          o_query_error
);
    import rks_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CapLen = (DEPTH > 2047) ? 2047 : DEPTH;
    localparam int VB = VALUE_BITS;

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_SCAN   = 6'b000100,
        ST_TALLY  = 6'b001000,
        ST_DECIDE = 6'b010000,
        ST_DONE   = 6'b100000
    } t_state;

    t_state         r_state, n_state;
    logic [AW-1:0]  r_addr, n_addr;
    logic [AW-1:0]  r_lo, n_lo;
    logic [AW-1:0]  r_hi, n_hi;
    logic [PW-1:0]  r_k, n_k;
    logic [PW-1:0]  r_zeros, n_zeros;
    logic [VB-1:0]  r_prefix, n_prefix;
    logic [VB-1:0]  r_fixed, n_fixed;
    logic [VB-1:0]  r_bit, n_bit;
    logic           r_pend;
    logic           r_err, n_err;

    logic [PW-1:0]  w_len;
    logic [PW:0]    w_span;
    logic           w_bad;
    logic           w_accept;
    logic           w_wr_ok;
    logic           w_hit;
    logic           w_we;
    logic [AW-1:0]  w_waddr;
    logic [VB-1:0]  w_wdata;
    logic [VB-1:0]  w_rdata;

    rks_store #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (r_state == ST_SCAN),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    assign w_len = (i_cfg_len > PW'(CapLen)) ? PW'(CapLen) : i_cfg_len;
    assign w_span = {1'b0, i_range_end} - {1'b0, i_position} + (PW+1)'(1);
    assign w_bad = (i_position == '0) || (i_range_end > w_len)
                || (i_position > i_range_end) || (i_rank == '0)
                || ({1'b0, i_rank} > w_span);

    assign o_req_ready = (r_state == ST_IDLE);
    assign w_accept = i_req_valid && o_req_ready;
    assign w_wr_ok = (i_position != '0) && (i_position <= w_len);

    always_comb begin
        if (r_state == ST_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_addr;
            w_wdata = '0;
        end else begin
            w_we    = w_accept && (i_kind == KIND_WRITE) && w_wr_ok;
            w_waddr = AW'(i_position - PW'(1));
            w_wdata = VB'(i_new_value);
        end
    end

    assign w_hit = r_pend && ((w_rdata & r_fixed) == r_prefix)
                && ((w_rdata & r_bit) == '0);

    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_k      = r_k;
        n_zeros  = w_hit ? r_zeros + PW'(1) : r_zeros;
        n_prefix = r_prefix;
        n_fixed  = r_fixed;
        n_bit    = r_bit;
        n_err    = r_err;
        unique case (r_state)
            ST_CLEAR: begin
                n_addr = r_addr + AW'(1);
                if (r_addr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept && i_kind == KIND_QUERY) begin
                    n_lo     = AW'(i_position - PW'(1));
                    n_hi     = AW'(i_range_end - PW'(1));
                    n_addr   = AW'(i_position - PW'(1));
                    n_k      = i_rank;
                    n_zeros  = '0;
                    n_prefix = '0;
                    n_fixed  = '0;
                    n_bit    = VB'(1) << (VB - 1);
                    n_err    = w_bad;
                    n_state  = w_bad ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_addr == r_hi) begin
                    n_state = ST_TALLY;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            ST_TALLY: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (r_k > r_zeros) begin
                    n_k      = r_k - r_zeros;
                    n_prefix = r_prefix | r_bit;
                end
                n_fixed = r_fixed | r_bit;
                n_zeros = '0;
                n_addr  = r_lo;
                n_bit   = r_bit >> 1;
                n_state = r_bit[0] ? ST_DONE : ST_SCAN;
            end
            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_addr  <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_pend  <= (r_state == ST_SCAN);
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_k      <= n_k;
        r_zeros  <= n_zeros;
        r_prefix <= n_prefix;
        r_fixed  <= n_fixed;
        r_bit    <= n_bit;
        r_err    <= n_err;
    end

    assign o_res_valid   = (r_state == ST_DONE);
    assign o_kth_value   = VALUE_W'(r_prefix);
    assign o_query_error = r_err;

endmodule

// File: sv/range_kth_smallest_with_update.sv
// Top level of the range k-th smallest block with element writes.
// After reset the block zeroes every entry of its element store and takes no request
// meanwhile (configuration writes are taken at any time). A valid query sweeps the range
// through the single read port of the store once for each value bit, most significant
// first, counting the entries that match the chosen prefix and hold a zero in that bit.
// A rejected query goes from idle straight to the result. Results wait in an output
// register, so a new request is taken while the previous result is still pending.
module range_kth_smallest_with_update #(
    parameter int DEPTH = rks_pkg::DEFAULT_DEPTH,
    parameter int VALUE_BITS = rks_pkg::DEFAULT_VALUE_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rks_pkg::PW-1:0]            i_cfg_data,     // array_length
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // position, range_end, new_value, rank, zero pad
    input  logic [rks_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic                              s_axis_tuser,   // kind
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [rks_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // kth_value
    output logic                              m_axis_tuser    // query_error
);
    import rks_pkg::*;

    logic [PW-1:0]          r_cfg_len;
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                   r_out_err;
    logic                   w_res_valid;
    logic                   w_res_ready;
    logic [VALUE_W-1:0]     w_kth_value;
    logic                   w_query_error;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_len <= CFG_LEN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cfg_len <= i_cfg_data;
        end
    end

    rks_engine #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_len     (r_cfg_len),
        .i_req_valid   (s_axis_tvalid),
        .o_req_ready   (s_axis_tready),
        .i_kind        (s_axis_tuser),
        .i_position    (s_axis_tdata[10:0]),
        .i_range_end   (s_axis_tdata[21:11]),
        .i_new_value   (s_axis_tdata[53:22]),
        .i_rank        (s_axis_tdata[64:54]),
        .o_res_valid   (w_res_valid),
        .i_res_ready   (w_res_ready),
        .o_kth_value   (w_kth_value),
        .o_query_error (w_query_error)
    );

    assign w_res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out_data <= w_kth_value;
            r_out_err  <= w_query_error;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_err;

endmodule

// File: sv/rks_checker.sv
// Port-level checks for the range k-th smallest block, bound to the top level.
module rks_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              s_axis_tuser,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [rks_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input logic                              m_axis_tuser
);
    import rks_pkg::*;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("flagged result carries a nonzero value");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_QUERY) |=> !s_axis_tready)
        else $error("request taken while a query is in progress");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("request taken before store clear");

endmodule

bind range_kth_smallest_with_update rks_checker u_rks_checker (.*);
